@@ rtl/core/utf16_to_utf8_transcoder_top_macros.svh @@
// Assertion macros for the UTF-16 to UTF-8 transcoder.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define UTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define UTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/utt_pkg.sv @@
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// Used by the front, the command queue, the back and the top level.
package utt_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned MaxW     = 13;
  localparam int unsigned CntW     = 3;

  localparam logic [MaxW-1:0] MaxBytesReset = 13'd128;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_LONE_LOW      = 3'd1,
    ST_UNPAIRED_HIGH = 3'd2,
    ST_ZERO          = 3'd3,
    ST_TOO_LONG      = 3'd4
  } status_e;

  // One queued command: the bytes of one code point, then an optional status.
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [CntW-1:0] nbytes;
    logic            has_status;
    status_e         status;
  } cmd_t;

endpackage

@@ rtl/core/utf16_to_utf8_transcoder_top.sv @@
// With the back part idle, the first result item of an accepted code unit
// passes through the command queue and then the back part's command register.
// Throughput: one result item per cycle while out_ready_i is high; a unit causes up
// to 5 items, and the next command loads as the last item of the current one leaves.
// The command queue (FIFO_DEPTH entries) lets input run ahead of output.
// Reset: asynchronous, active low; clears run state, queue and max_bytes to 128.
`include "utf16_to_utf8_transcoder_top_macros.svh"

module utf16_to_utf8_transcoder_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        start_string_i,
  input  logic        end_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        is_status_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o
);

  utt_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, full, pop, cmd_valid;

  utt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .start_string_i (start_string_i),
    .end_string_i   (end_string_i),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full)
  );

  utt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .valid_o (cmd_valid)
  );

  utt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .is_status_o   (is_status_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  `UTT_ASSERT_NOW(a_byte_ok, out_valid_o && !is_status_o, status_o == utt_pkg::ST_OK, "byte item with status")
  `UTT_ASSERT_NOW(a_status_last, out_valid_o && is_status_o, last_of_run_o, "status item not last")
  `UTT_ASSERT_NOW(a_no_bad_lead, out_valid_o && !is_status_o, data_byte_o[7:3] != 5'b11111, "bad byte")
  `UTT_ASSERT_NEXT(a_status_held, out_valid_o && is_status_o && !out_ready_i, is_status_o, "status lost")

endmodule

@@ rtl/core/utt_front.sv @@
// Front part: accepts code units, tracks run state and byte budget.
// Emits one utt_pkg::cmd_t per item that causes results.
module utt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [utt_pkg::MaxW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [15:0]                 code_unit_i,
  input  logic                        start_string_i,
  input  logic                        end_string_i,
  output logic                        push_o,
  output utt_pkg::cmd_t               cmd_o,
  input  logic                        full_i
);

  logic [utt_pkg::MaxW-1:0] max_q;
  logic [9:0]               ph_q, ph_d, ph_eff;
  logic                     have_q, have_d, have_eff;
  logic [utt_pkg::MaxW-1:0] used_q, used_d, used_eff;
  utt_pkg::status_e         err_q, err_d, err_eff;

  logic                     accept;
  logic                     is_high, is_low;
  logic                     emit;
  logic [utt_pkg::CntW-1:0] need;
  logic [utt_pkg::CpW-1:0]  cp;
  logic [utt_pkg::MaxW:0]   sum;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_high    = (code_unit_i[15:10] == 6'b110110);
  assign is_low     = (code_unit_i[15:10] == 6'b110111);

  // A start unit sees a cleared run.
  assign ph_eff   = start_string_i ? '0 : ph_q;
  assign have_eff = start_string_i ? 1'b0 : have_q;
  assign used_eff = start_string_i ? '0 : used_q;
  assign err_eff  = start_string_i ? utt_pkg::ST_OK : err_q;

  always_comb begin
    ph_d   = ph_eff;
    have_d = have_eff;
    used_d = used_eff;
    err_d  = err_eff;
    emit   = 1'b0;
    need   = '0;
    cp     = '0;
    cmd_o  = '{cp: '0, nbytes: '0, has_status: 1'b0, status: utt_pkg::ST_OK};

    if (err_eff == utt_pkg::ST_OK) begin
      if (have_eff) begin
        have_d = 1'b0;
        ph_d   = '0;
        if (is_low) begin
          // 0x10000 + (high << 10) + low offset
          emit = 1'b1;
          cp   = {({1'b0, ph_eff} + 11'd64), code_unit_i[9:0]};
          need = 3'd4;
        end else begin
          err_d = utt_pkg::ST_UNPAIRED_HIGH;
        end
      end else if (is_high) begin
        ph_d   = code_unit_i[9:0];
        have_d = 1'b1;
      end else if (is_low) begin
        err_d = utt_pkg::ST_LONE_LOW;
      end else begin
        emit = 1'b1;
        cp   = {5'b0, code_unit_i};
        if (code_unit_i[15:7] == '0) begin
          need = 3'd1;
        end else if (code_unit_i[15:11] == '0) begin
          need = 3'd2;
        end else begin
          need = 3'd3;
        end
      end
    end

    sum = {1'b0, used_eff} + {{(utt_pkg::MaxW + 1 - utt_pkg::CntW){1'b0}}, need};

    cmd_o.cp = cp;
    if (emit) begin
      if (cp == '0) begin
        err_d = utt_pkg::ST_ZERO;
      end else if (sum > {1'b0, max_q}) begin
        err_d = utt_pkg::ST_TOO_LONG;
      end else begin
        used_d       = sum[utt_pkg::MaxW-1:0];
        cmd_o.nbytes = need;
      end
    end

    if (end_string_i) begin
      if (err_d == utt_pkg::ST_OK && have_d) begin
        err_d = utt_pkg::ST_UNPAIRED_HIGH;
      end
      cmd_o.has_status = 1'b1;
      cmd_o.status     = err_d;
      // Close the run.
      ph_d   = '0;
      have_d = 1'b0;
      used_d = '0;
      err_d  = utt_pkg::ST_OK;
    end
  end

  assign push_o = accept && (cmd_o.nbytes != '0 || end_string_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= utt_pkg::MaxBytesReset;
      ph_q   <= '0;
      have_q <= 1'b0;
      used_q <= '0;
      err_q  <= utt_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        ph_q   <= ph_d;
        have_q <= have_d;
        used_q <= used_d;
        err_q  <= err_d;
      end
    end
  end

endmodule

@@ rtl/core/utt_fifo.sv @@
// Command queue between front and back of the transcoder.
// Holds utt_pkg::cmd_t entries in a small register array.
module utt_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utt_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output utt_pkg::cmd_t rdata_o,
  output logic          valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  utt_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/core/utt_back.sv @@
// Back part: serializes one queued command into UTF-8 byte items
// and an optional closing status item. Depends on utt_pkg.
module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  utt_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    data_byte_o,
  output logic          is_status_o,
  output logic [2:0]    status_o,
  output logic          last_of_run_o
);

  utt_pkg::cmd_t            cur_q;
  logic                     busy_q;
  logic [utt_pkg::CntW-1:0] idx_q;
  logic [utt_pkg::CntW-1:0] total;
  logic                     is_byte;
  logic                     last;

  assign total   = cur_q.nbytes + {{(utt_pkg::CntW - 1){1'b0}}, cur_q.has_status};
  assign is_byte = (idx_q < cur_q.nbytes);
  assign last    = (idx_q == total - utt_pkg::CntW'(1));
  assign pop_o   = cmd_valid_i && (!busy_q || (out_ready_i && last));

  assign out_valid_o   = busy_q;
  assign is_status_o   = !is_byte;
  assign status_o      = is_byte ? utt_pkg::ST_OK : cur_q.status;
  assign last_of_run_o = last;

  always_comb begin
    data_byte_o = 8'h00;
    if (is_byte) begin
      unique case (cur_q.nbytes)
        3'd1: data_byte_o = {1'b0, cur_q.cp[6:0]};
        3'd2: begin
          data_byte_o = (idx_q == 3'd0) ? {3'b110, cur_q.cp[10:6]} : {2'b10, cur_q.cp[5:0]};
        end
        3'd3: begin
          unique case (idx_q)
            3'd0:    data_byte_o = {4'b1110, cur_q.cp[15:12]};
            3'd1:    data_byte_o = {2'b10, cur_q.cp[11:6]};
            default: data_byte_o = {2'b10, cur_q.cp[5:0]};
          endcase
        end
        3'd4: begin
          unique case (idx_q)
            3'd0:    data_byte_o = {5'b11110, cur_q.cp[20:18]};
            3'd1:    data_byte_o = {2'b10, cur_q.cp[17:12]};
            3'd2:    data_byte_o = {2'b10, cur_q.cp[11:6]};
            default: data_byte_o = {2'b10, cur_q.cp[5:0]};
          endcase
        end
        default: data_byte_o = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
  end

  // Load the next command when idle or as the last item of the current one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + utt_pkg::CntW'(1);
      end
    end
  end

endmodule

@@ dv/utf16_to_utf8_transcoder_top_test.sv @@
// Testbench for utf16_to_utf8_transcoder_top: streams UTF-16 strings through the
// block and checks every UTF-8 byte and status item against its own predictor.
// Depends on utt_pkg and the transcoder RTL only.
module utf16_to_utf8_transcoder_top_test;

  localparam int NumPhases   = 8;
  localparam int PhaseUnits  = 48;
  localparam int DrainCycles = 30;
  localparam int LongHold    = 400;

  typedef struct packed {
    logic [15:0] cu;
    logic        sos;
    logic        eos;
  } utf16_unit_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             is_status;
    utt_pkg::status_e status;
    logic             last_of_run;
  } utf8_item_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [12:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_unit   = '0;
  logic        start_string = 1'b0;
  logic        end_string  = 1'b0;
  logic        out_valid_o;
  logic        out_ready   = 1'b0;
  logic [7:0]  data_byte_o;
  logic        is_status_o;
  logic [2:0]  status_o;
  logic        last_of_run_o;

  utf16_unit_t utf16_pending_q[$];
  utf8_item_t  utf8_expect_q[$];
  int          units_queued   = 0;
  int          accepted_units = 0;
  int          mismatches     = 0;
  logic        idle_on        = 1'b1;
  int          send_gap       = 0;
  int          hold_left      = 0;
  logic        long_hold_done = 1'b0;

  // Predictor state
  logic [12:0]      byte_budget = utt_pkg::MaxBytesReset;
  logic [9:0]       held_high   = '0;
  logic             high_held   = 1'b0;
  logic [12:0]      bytes_sent  = '0;
  utt_pkg::status_e run_status  = utt_pkg::ST_OK;

  utf16_to_utf8_transcoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit),
    .start_string_i (start_string),
    .end_string_i   (end_string),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .data_byte_o    (data_byte_o),
    .is_status_o    (is_status_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void restart_string();
    held_high  = '0;
    high_held  = 1'b0;
    bytes_sent = '0;
    run_status = utt_pkg::ST_OK;
  endfunction

  function automatic void expect_byte(input logic [7:0] b);
    utf8_item_t it;
    it = '{data_byte: b, is_status: 1'b0, status: utt_pkg::ST_OK, last_of_run: 1'b0};
    utf8_expect_q.insert(utf8_expect_q.size(), it);
  endfunction

  // Encode one code point against the byte budget; returns the bytes queued.
  function automatic int utf8_encode(input logic [20:0] cp);
    int need;
    if (cp == '0) begin
      run_status = utt_pkg::ST_ZERO;
      return 0;
    end
    need = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
    if (int'(bytes_sent) + need > int'(byte_budget)) begin
      run_status = utt_pkg::ST_TOO_LONG;
      return 0;
    end
    bytes_sent = bytes_sent + 13'(need);
    case (need)
      1: expect_byte(cp[7:0]);
      2: begin
        expect_byte({3'b110, cp[10:6]});
        expect_byte({2'b10, cp[5:0]});
      end
      3: begin
        expect_byte({4'b1110, cp[15:12]});
        expect_byte({2'b10, cp[11:6]});
        expect_byte({2'b10, cp[5:0]});
      end
      default: begin
        expect_byte({5'b11110, cp[20:18]});
        expect_byte({2'b10, cp[17:12]});
        expect_byte({2'b10, cp[11:6]});
        expect_byte({2'b10, cp[5:0]});
      end
    endcase
    return need;
  endfunction

  // Work out the items one accepted code unit causes.
  function automatic void predict_utf8(input logic [15:0] cu, input logic sos,
                                       input logic eos);
    logic       is_high;
    logic       is_low;
    int         n;
    utf8_item_t it;
    is_high = (cu >= 16'hD800) && (cu <= 16'hDBFF);
    is_low  = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
    n = 0;
    if (sos) restart_string();
    if (run_status == utt_pkg::ST_OK) begin
      if (high_held) begin
        high_held = 1'b0;
        if (is_low) begin
          n = utf8_encode(21'h10000 + {1'b0, held_high, cu[9:0]});
        end else begin
          run_status = utt_pkg::ST_UNPAIRED_HIGH;
        end
        held_high = '0;
      end else if (is_high) begin
        held_high = cu[9:0];
        high_held = 1'b1;
      end else if (is_low) begin
        run_status = utt_pkg::ST_LONE_LOW;
      end else begin
        n = utf8_encode({5'd0, cu});
      end
    end
    if (eos) begin
      if (run_status == utt_pkg::ST_OK && high_held) run_status = utt_pkg::ST_UNPAIRED_HIGH;
      it = '{data_byte: 8'h00, is_status: 1'b1, status: run_status, last_of_run: 1'b0};
      utf8_expect_q.insert(utf8_expect_q.size(), it);
      n++;
      restart_string();
    end
    if (n > 0) begin
      it = utf8_expect_q.pop_back();
      it.last_of_run = 1'b1;
      utf8_expect_q.insert(utf8_expect_q.size(), it);
    end
  endfunction

  // Sender: present queued units, with random gaps between them while idle_on is set.
  always @(posedge clk_i) begin
    utf16_unit_t nxt;
    if (in_valid && in_ready_o) begin
      predict_utf8(code_unit, start_string, end_string);
      accepted_units <= accepted_units + 1;
    end
    if (rst_ni && !(in_valid && !in_ready_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (utf16_pending_q.size() != 0) begin
        nxt = utf16_pending_q.pop_front();
        code_unit    <= nxt.cu;
        start_string <= nxt.sos;
        end_string   <= nxt.eos;
        in_valid     <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls while idle_on is set, plus one long hold-off to back up the queue.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && accepted_units >= 60) begin
      long_hold_done <= 1'b1;
      hold_left      <= LongHold;
      out_ready      <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    utf8_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready) begin
      if (utf8_expect_q.size() == 0) begin
        $error("unexpected item: data_byte 0x%0h is_status %0b status %0d",
               data_byte_o, is_status_o, status_o);
        mismatches++;
      end else begin
        exp_item = utf8_expect_q.pop_front();
        check_field("data_byte", exp_item.data_byte, data_byte_o);
        check_field("is_status", 8'(exp_item.is_status), 8'(is_status_o));
        check_field("status", 8'(exp_item.status), 8'(status_o));
        check_field("last_of_run", 8'(exp_item.last_of_run), 8'(last_of_run_o));
      end
    end
  end

  task automatic queue_unit(input logic [15:0] cu, input logic sos, input logic eos);
    utf16_unit_t u;
    u = '{cu: cu, sos: sos, eos: eos};
    utf16_pending_q.insert(utf16_pending_q.size(), u);
    units_queued++;
  endtask

  // Hold until every unit is accepted and every item seen, then let the
  // block settle units that cause no item.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (utf16_pending_q.size() != 0 || in_valid || utf8_expect_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_budget(input logic [12:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    byte_budget = value;
    @(negedge clk_i);
  endtask

  // Mostly well-formed strings with random content; rare faults.
  task automatic queue_random_string();
    logic [15:0] body[$];
    logic [15:0] u;
    int          len;
    int          pick;
    int          i;
    len = $urandom_range(1, 8);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 29);
      if (pick < 8) begin
        body.insert(body.size(), 16'($urandom_range(1, 'h7F)));
      end else if (pick < 14) begin
        body.insert(body.size(), 16'($urandom_range('h80, 'h7FF)));
      end else if (pick < 20) begin
        u = 16'($urandom_range('h800, 'hF7FF));
        if (u >= 16'hD800) u = u + 16'h0800;
        body.insert(body.size(), u);
      end else if (pick < 28) begin
        body.insert(body.size(), 16'($urandom_range('hD800, 'hDBFF)));
        body.insert(body.size(), 16'($urandom_range('hDC00, 'hDFFF)));
      end else begin
        case ($urandom_range(0, 3))
          0: body.insert(body.size(), 16'h0000);
          1: body.insert(body.size(), 16'($urandom_range('hDC00, 'hDFFF)));
          2: begin
            body.insert(body.size(), 16'($urandom_range('hD800, 'hDBFF)));
            body.insert(body.size(), 16'($urandom_range(1, 'hD7FF)));
          end
          default: body.insert(body.size(), 16'($urandom_range('hD800, 'hDBFF)));
        endcase
      end
    end
    for (i = 0; i < body.size(); i++) begin
      queue_unit(body[i], (i == 0) && ($urandom_range(0, 7) != 0), i == body.size() - 1);
    end
  endtask

  initial begin
    logic [12:0] phase_budget [NumPhases];
    int          target;
    int          p;
    phase_budget = '{13'd128, 13'd4096, 13'd20, 13'd8191, 13'd0, 13'd1, 13'd4, 13'd128};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default budget: one of each byte length, extreme pairs, each error kind but too long.
    queue_unit(16'h0041, 1'b1, 1'b1);
    queue_unit(16'h007F, 1'b1, 1'b0);
    queue_unit(16'h0080, 1'b0, 1'b0);
    queue_unit(16'h07FF, 1'b0, 1'b0);
    queue_unit(16'h0800, 1'b0, 1'b0);
    queue_unit(16'hFFFF, 1'b0, 1'b0);
    queue_unit(16'hD800, 1'b0, 1'b0);
    queue_unit(16'hDC00, 1'b0, 1'b0);
    queue_unit(16'hDBFF, 1'b0, 1'b0);
    queue_unit(16'hDFFF, 1'b0, 1'b1);
    queue_unit(16'hDC00, 1'b1, 1'b0);   // lone low, then no more bytes
    queue_unit(16'h0041, 1'b0, 1'b0);
    queue_unit(16'h0042, 1'b0, 1'b1);
    queue_unit(16'hD801, 1'b1, 1'b0);   // high followed by a plain unit
    queue_unit(16'h0041, 1'b0, 1'b1);
    queue_unit(16'hDBFF, 1'b1, 1'b1);   // high held at the end
    queue_unit(16'h0000, 1'b1, 1'b1);
    queue_unit(16'h0043, 1'b0, 1'b1);   // new string without a start mark
    queue_unit(16'h0044, 1'b0, 1'b0);   // left open, then restarted
    queue_unit(16'h0045, 1'b1, 1'b1);
    wait_drained();

    // Budget of four: overrun, then an exact fit of four bytes.
    write_budget(13'd4);
    queue_unit(16'h0041, 1'b1, 1'b0);
    queue_unit(16'h0042, 1'b0, 1'b0);
    queue_unit(16'h0800, 1'b0, 1'b1);
    queue_unit(16'hD83D, 1'b1, 1'b0);
    queue_unit(16'hDE00, 1'b0, 1'b1);

    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_budget(phase_budget[p]);
      idle_on = (p != 3) && (p != NumPhases - 1);
      target = units_queued + PhaseUnits;
      while (units_queued < target) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_unit(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0);
        end else begin
          queue_random_string();
        end
      end
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
